### rtl/tfn_pkg.sv
`default_nettype none
package tfn_pkg;
   // width of every coordinate and normal field on the ports
   localparam int FIELD_W = 16;
   localparam int NUM_IN_FIELDS = 9;
   localparam int NUM_OUT_FIELDS = 3;
   localparam int DEF_COORD_WIDTH = 16;
   localparam int DEF_NORMAL_FRAC_BITS = 14;

   // control that travels beside each item: valid and component signs
   typedef struct packed {
      logic       valid;
      logic [2:0] neg;
   } ctl_type;
endpackage
`default_nettype wire

### rtl/triangle_face_normal.sv
`default_nettype none
// Unit face normal of a triangle. Each item carries three vertices; the block
// forms the edges from the first vertex, takes their cross product exactly and
// gives each component divided by the vector length, rounded to nearest (ties
// away from zero) and at most plus or minus one. A zero cross product gives
// the zero vector with degenerate set. The pipeline takes one item every cycle
// and holds everything while the result side stalls. An item passes through
// the edges and cross product, the squared length, the divide-and-root chain
// that settles the result bits in turn from the top (each stage one trial
// compare over the wide squared terms) and the output register.
module triangle_face_normal
   import tfn_pkg::*;
#(
   parameter int COORD_WIDTH = DEF_COORD_WIDTH,
   parameter int NORMAL_FRAC_BITS = DEF_NORMAL_FRAC_BITS
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z
   input  wire logic [NUM_IN_FIELDS*FIELD_W-1:0] req_tdata,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // norm_x, norm_y, norm_z
   output logic [NUM_OUT_FIELDS*FIELD_W-1:0]     rsp_tdata,
   // degenerate
   output logic                                  rsp_tuser
);
   localparam int F  = NORMAL_FRAC_BITS;
   localparam int MW = 2 * (COORD_WIDTH + 1) + 1;
   localparam int SW = 2 * MW + 2;
   localparam int WD = SW + 2 * F + 6;

   logic                        adv;
   ctl_type                     cr_ctl;
   logic [2:0][MW-1:0]          cr_mag;
   ctl_type                     ns_ctl;
   logic [2:0][2*MW-1:0]        ns_sq;
   logic [SW-1:0]               ns_sum;
   ctl_type                     ch_ctl [F+2];
   logic [SW-1:0]               ch_sum [F+2];
   logic [2:0][WD-1:0]          ch_r   [F+2];
   logic [2:0][WD-1:0]          ch_p   [F+2];
   logic [2:0][WD-1:0]          ch_q1  [F+2];
   logic [2:0][F:0]             ch_q   [F+2];
   logic                        degen;
   logic [NUM_OUT_FIELDS*FIELD_W-1:0] data_in;
   logic                        rsp_valid_ff;
   logic [NUM_OUT_FIELDS*FIELD_W-1:0] rsp_data_ff;
   logic                        rsp_degen_ff;

   // advance the whole pipeline unless the output item is stuck
   assign adv        = !rsp_valid_ff || rsp_tready;
   assign req_tready = adv;

   tfn_cross #(.COORD_WIDTH(COORD_WIDTH), .MW(MW)) u_cross (
      .clock(clock), .reset(reset), .adv(adv),
      .in_valid(req_tvalid), .in_data(req_tdata),
      .out_ctl(cr_ctl), .out_mag(cr_mag)
   );

   tfn_norm_sq #(.MW(MW)) u_norm_sq (
      .clock(clock), .reset(reset), .adv(adv),
      .in_ctl(cr_ctl), .in_mag(cr_mag),
      .out_ctl(ns_ctl), .out_sq(ns_sq), .out_sum(ns_sum)
   );

   // seed the chain with q = 0: P = S, Q1 = -S, bound 4 m^2 2^(2F)
   always_comb begin
      ch_ctl[0] = ns_ctl;
      ch_sum[0] = ns_sum;
      for (int i = 0; i < 3; i++) begin
         ch_r[0][i]  = WD'(ns_sq[i]) << (2*F + 2);
         ch_p[0][i]  = WD'(ns_sum);
         ch_q1[0][i] = -WD'(ns_sum);
         ch_q[0][i]  = '0;
      end
   end

   for (genvar g = 0; g <= F; g++) begin : g_div
      tfn_div_stage #(.K(F - g), .F(F), .SW(SW), .WD(WD)) u_stage (
         .clock(clock), .reset(reset), .adv(adv),
         .in_ctl(ch_ctl[g]), .in_sum(ch_sum[g]), .in_r(ch_r[g]),
         .in_p(ch_p[g]), .in_q1(ch_q1[g]), .in_q(ch_q[g]),
         .out_ctl(ch_ctl[g+1]), .out_sum(ch_sum[g+1]), .out_r(ch_r[g+1]),
         .out_p(ch_p[g+1]), .out_q1(ch_q1[g+1]), .out_q(ch_q[g+1])
      );
   end

   // apply signs, force zero on a degenerate triangle
   always_comb begin
      logic [FIELD_W-1:0] code;
      degen = ch_sum[F+1] == '0;
      for (int i = 0; i < 3; i++) begin
         code = FIELD_W'(ch_q[F+1][i]);
         if (degen) begin
            code = '0;
         end else if (ch_ctl[F+1].neg[i]) begin
            code = -code;
         end
         data_in[i*FIELD_W +: FIELD_W] = code;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= ch_ctl[F+1].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff  <= data_in;
         rsp_degen_ff <= degen;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_degen_ff;

`ifndef ASSERT_OFF
   // degenerate item carries the zero vector
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata == '0))
      else $error("degenerate item with nonzero normal");
   // a real normal has some nonzero component
   a_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser && F <= FIELD_W - 2) |-> (rsp_tdata != '0))
      else $error("zero normal without degenerate flag");
   // nothing leaves right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("output valid after reset");
`endif
endmodule
`default_nettype wire

### rtl/tfn_cross.sv
`default_nettype none
module tfn_cross
   import tfn_pkg::*;
#(
   parameter int COORD_WIDTH = DEF_COORD_WIDTH,
   parameter int MW = 2 * (COORD_WIDTH + 1) + 1
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             adv,
   input  wire logic                             in_valid,
   input  wire logic [NUM_IN_FIELDS*FIELD_W-1:0] in_data,
   output ctl_type                               out_ctl,
   output logic [2:0][MW-1:0]                    out_mag
);
   localparam int CW = COORD_WIDTH;
   localparam int EW = CW + 1;
   localparam int PW = 2 * EW;
   localparam int XW = (CW > FIELD_W) ? CW : FIELD_W;

   logic signed [CW-1:0] crd [NUM_IN_FIELDS];
   logic signed [EW-1:0] u_in [3];
   logic signed [EW-1:0] v_in [3];
   logic signed [EW-1:0] u_ff [3];
   logic signed [EW-1:0] v_ff [3];
   logic                 va_ff;
   logic signed [PW-1:0] pr_in [6];
   logic signed [PW-1:0] pr_ff [6];
   logic                 vb_ff;
   logic signed [MW-1:0] n_in [3];
   logic [2:0]           neg_in;
   logic [2:0][MW-1:0]   mag_in;
   ctl_type              ctl_ff;
   logic [2:0][MW-1:0]   mag_ff;

   // take each coordinate from the low bits of its field
   always_comb begin
      logic [XW-1:0] fext;
      for (int j = 0; j < NUM_IN_FIELDS; j++) begin
         fext = XW'(in_data[j*FIELD_W +: FIELD_W]);
         crd[j] = signed'(fext[CW-1:0]);
      end
   end

   // form the edges from the first vertex
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         u_in[i] = EW'(crd[3+i]) - EW'(crd[i]);
         v_in[i] = EW'(crd[6+i]) - EW'(crd[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
      end else if (adv) begin
         va_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         u_ff <= u_in;
         v_ff <= v_in;
      end
   end

   // cross product terms, one multiplier each
   always_comb begin
      pr_in[0] = PW'(u_ff[1]) * PW'(v_ff[2]);
      pr_in[1] = PW'(u_ff[2]) * PW'(v_ff[1]);
      pr_in[2] = PW'(u_ff[2]) * PW'(v_ff[0]);
      pr_in[3] = PW'(u_ff[0]) * PW'(v_ff[2]);
      pr_in[4] = PW'(u_ff[0]) * PW'(v_ff[1]);
      pr_in[5] = PW'(u_ff[1]) * PW'(v_ff[0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vb_ff <= 1'b0;
      end else if (adv) begin
         vb_ff <= va_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pr_ff <= pr_in;
      end
   end

   // subtract term pairs and split into sign and magnitude
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         n_in[i] = MW'(pr_ff[2*i]) - MW'(pr_ff[2*i+1]);
         neg_in[i] = n_in[i][MW-1];
         mag_in[i] = neg_in[i] ? MW'(-n_in[i]) : MW'(n_in[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else if (adv) begin
         ctl_ff.valid <= vb_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ctl_ff.neg <= neg_in;
         mag_ff     <= mag_in;
      end
   end

   assign out_ctl = ctl_ff;
   assign out_mag = mag_ff;
endmodule
`default_nettype wire

### rtl/tfn_norm_sq.sv
`default_nettype none
module tfn_norm_sq
   import tfn_pkg::*;
#(
   parameter int MW = 35
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  adv,
   input  wire ctl_type               in_ctl,
   input  wire logic [2:0][MW-1:0]    in_mag,
   output ctl_type                    out_ctl,
   output logic [2:0][2*MW-1:0]       out_sq,
   output logic [2*MW+1:0]            out_sum
);
   localparam int H = (MW + 1) / 2;
   localparam int HW = MW - H;
   localparam int QW = 2 * MW;
   localparam int SW = 2 * MW + 2;

   ctl_type              ca_ff;
   logic [2:0][2*HW-1:0] hh_ff;
   logic [2:0][HW+H-1:0] hl_ff;
   logic [2:0][2*H-1:0]  ll_ff;
   ctl_type              cb_ff;
   logic [2:0][QW-1:0]   sq_in;
   logic [2:0][QW-1:0]   sq_ff;
   ctl_type              cc_ff;
   logic [2:0][QW-1:0]   sqc_ff;
   logic [SW-1:0]        sum_ff;

   // partial products of the split magnitude
   always_ff @(posedge clock) begin
      if (reset) begin
         ca_ff.valid <= 1'b0;
      end else if (adv) begin
         ca_ff.valid <= in_ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ca_ff.neg <= in_ctl.neg;
         for (int i = 0; i < 3; i++) begin
            hh_ff[i] <= (2*HW)'(in_mag[i][MW-1:H]) * (2*HW)'(in_mag[i][MW-1:H]);
            hl_ff[i] <= (HW+H)'(in_mag[i][MW-1:H]) * (HW+H)'(in_mag[i][H-1:0]);
            ll_ff[i] <= (2*H)'(in_mag[i][H-1:0]) * (2*H)'(in_mag[i][H-1:0]);
         end
      end
   end

   // recombine into full squares
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sq_in[i] = (QW'(hh_ff[i]) << (2*H)) + (QW'(hl_ff[i]) << (H+1)) + QW'(ll_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cb_ff.valid <= 1'b0;
      end else if (adv) begin
         cb_ff.valid <= ca_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cb_ff.neg <= ca_ff.neg;
         sq_ff     <= sq_in;
      end
   end

   // add the three squares
   always_ff @(posedge clock) begin
      if (reset) begin
         cc_ff.valid <= 1'b0;
      end else if (adv) begin
         cc_ff.valid <= cb_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cc_ff.neg <= cb_ff.neg;
         sqc_ff    <= sq_ff;
         sum_ff    <= SW'(sq_ff[0]) + SW'(sq_ff[1]) + SW'(sq_ff[2]);
      end
   end

   assign out_ctl = cc_ff;
   assign out_sq  = sqc_ff;
   assign out_sum = sum_ff;
endmodule
`default_nettype wire

### rtl/tfn_div_stage.sv
`default_nettype none
module tfn_div_stage
   import tfn_pkg::*;
#(
   parameter int K  = 0,
   parameter int F  = DEF_NORMAL_FRAC_BITS,
   parameter int SW = 72,
   parameter int WD = 100
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   adv,
   input  wire ctl_type                in_ctl,
   input  wire logic [SW-1:0]          in_sum,
   input  wire logic [2:0][WD-1:0]     in_r,
   input  wire logic [2:0][WD-1:0]     in_p,
   input  wire logic [2:0][WD-1:0]     in_q1,
   input  wire logic [2:0][F:0]        in_q,
   output ctl_type                     out_ctl,
   output logic [SW-1:0]               out_sum,
   output logic [2:0][WD-1:0]          out_r,
   output logic [2:0][WD-1:0]          out_p,
   output logic [2:0][WD-1:0]          out_q1,
   output logic [2:0][F:0]             out_q
);
   logic [WD-1:0]      sw;
   logic [2:0][WD-1:0] pt;
   logic [2:0]         take;
   logic [2:0][WD-1:0] p_in;
   logic [2:0][WD-1:0] q1_in;
   logic [2:0][F:0]    q_in;
   ctl_type            ctl_ff;
   logic [SW-1:0]      sum_ff;
   logic [2:0][WD-1:0] r_ff;
   logic [2:0][WD-1:0] p_ff;
   logic [2:0][WD-1:0] q1_ff;
   logic [2:0][F:0]    q_ff;

   // try setting bit K: S*(2q-1)^2 grows by 4b*S*(2q-1) + 4b^2*S
   always_comb begin
      sw = WD'(in_sum);
      for (int i = 0; i < 3; i++) begin
         pt[i]    = in_p[i] + (in_q1[i] << (K + 2)) + (sw << (2*K + 2));
         take[i]  = $signed(pt[i]) <= $signed(in_r[i]);
         p_in[i]  = take[i] ? pt[i] : in_p[i];
         q1_in[i] = take[i] ? in_q1[i] + (sw << (K + 1)) : in_q1[i];
         q_in[i]  = in_q[i];
         q_in[i][K] = take[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else if (adv) begin
         ctl_ff.valid <= in_ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ctl_ff.neg <= in_ctl.neg;
         sum_ff     <= in_sum;
         r_ff       <= in_r;
         p_ff       <= p_in;
         q1_ff      <= q1_in;
         q_ff       <= q_in;
      end
   end

   assign out_ctl = ctl_ff;
   assign out_sum = sum_ff;
   assign out_r   = r_ff;
   assign out_p   = p_ff;
   assign out_q1  = q1_ff;
   assign out_q   = q_ff;

`ifndef ASSERT_OFF
   // once a bit is accepted the trial value stays within the bound
   a_p_bound: assert property (@(posedge clock) disable iff (reset)
      ctl_ff.valid |-> ((q_ff[0] == '0 || $signed(p_ff[0]) <= $signed(r_ff[0])) &&
                        (q_ff[1] == '0 || $signed(p_ff[1]) <= $signed(r_ff[1])) &&
                        (q_ff[2] == '0 || $signed(p_ff[2]) <= $signed(r_ff[2]))))
      else $error("trial product above bound");
   // bits below K of the first component are still clear
   a_low_clear: assert property (@(posedge clock) disable iff (reset)
      (ctl_ff.valid && K > 0) |-> ((q_ff[0] & ((F+1)'(1) << K) - (F+1)'(1)) == '0))
      else $error("low quotient bits set early");
   // in the first component a set top bit leaves no room for another
   a_top_alone: assert property (@(posedge clock) disable iff (reset)
      (ctl_ff.valid && sum_ff != '0 && q_ff[0][F] && K < F) |-> !q_ff[0][K])
      else $error("bit set above full scale");
`endif
endmodule
`default_nettype wire
